// File: rtl/cddn_pkg.sv
// Shared types, constants and calendar helper functions for the date converter.
`default_nettype none

package cddn_pkg;

   // Default year window
   localparam int unsigned DEF_FIRST_YEAR = 1900;
   localparam int unsigned DEF_LAST_YEAR  = 2099;

   // Field widths
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned COUNT_W = 17;
   localparam int unsigned WDAY_W  = 3;
   localparam int unsigned LEN_W   = 9;   // holds 366
   localparam int unsigned ACC_W   = 22;  // running count over the widest window

   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
   localparam logic [MONTH_W-1:0] FIRST_MONTH     = 4'd1;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic                 opcode;
      logic [MONTH_W-1:0]   month_in;
      logic [DAY_W-1:0]     day_in;
      logic [YEAR_W-1:0]    year_in;
      logic [COUNT_W-1:0]   count_in;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   count_out;
      logic [MONTH_W-1:0]   month_out;
      logic [DAY_W-1:0]     day_out;
      logic [YEAR_W-1:0]    year_out;
      logic [WDAY_W-1:0]    weekday;
      logic                 valid_res;
   } rsp_type;

   // Result of the shared add/subtract unit
   typedef struct packed {
      logic [ACC_W-1:0] sum;
      logic             borrow;
      logic             zero;
   } unit_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENC_CHECK,
      ST_ENC_YEAR,
      ST_ENC_DAY,
      ST_ENC_MONTH,
      ST_ENC_RANGE,
      ST_DEC_CHECK,
      ST_DEC_YEAR,
      ST_DEC_MONTH,
      ST_RESULT
   } state_type;

   // Sequencer controls
   typedef struct packed {
      logic load;
      logic acc_we;
      logic sub;
      logic use_year;
      logic year_step;
      logic month_step;
      logic ok_set;
      logic strobe;
   } ctl_type;

   // Length of a month; February follows the leap flag
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [LEN_W-1:0] year_len(input logic leap);
      return leap ? 9'd366 : 9'd365;
   endfunction

   // ((c + 5) mod 7) + 1, by folding octal digits (8 is 1 mod 7)
   function automatic logic [WDAY_W-1:0] weekday_of(input logic [COUNT_W-1:0] c);
      logic [COUNT_W:0] v;
      logic [5:0]       s1;
      logic [3:0]       s2;
      logic [3:0]       s3;
      v  = {1'b0, c} + 18'd5;
      s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
         + 6'(v[14:12]) + 6'(v[17:15]);
      s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
      s3 = 4'(s2[2:0]) + 4'(s2[3]);
      if (s3 >= 4'd7) begin
         s3 = s3 - 4'd7;
      end
      return s3[WDAY_W-1:0] + 3'd1;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cddn_unit.sv
// Shared add/subtract unit for the running day count.
`default_nettype none

module cddn_unit (
   input  wire logic [cddn_pkg::ACC_W-1:0] a,
   input  wire logic [cddn_pkg::LEN_W-1:0] b,
   input  wire logic                       sub,
   output cddn_pkg::unit_res_type          res
);
   import cddn_pkg::*;

   logic [ACC_W-1:0] b_ext;
   logic [ACC_W:0]   total;

   // One adder: a + b, or a + ~b + 1 for a - b
   assign b_ext = sub ? ~ACC_W'(b) : ACC_W'(b);
   assign total = {1'b0, a} + {1'b0, b_ext} + (ACC_W+1)'(sub);

   assign res.sum    = total[ACC_W-1:0];
   assign res.borrow = sub & ~total[ACC_W];
   assign res.zero   = (total[ACC_W-1:0] == '0);

endmodule

`default_nettype wire

// File: rtl/cddn_year.sv
// Year stepper with running residues for the Gregorian leap rule.
`default_nettype none

module cddn_year #(
   parameter int unsigned FIRST_YEAR = cddn_pkg::DEF_FIRST_YEAR
) (
   input  wire logic                        clock,
   input  wire logic                        load,
   input  wire logic                        step,
   output logic [cddn_pkg::YEAR_W-1:0]      year,
   output logic                             leap
);
   import cddn_pkg::*;

   localparam logic [YEAR_W-1:0] Y_INIT    = YEAR_W'(FIRST_YEAR);
   localparam logic [1:0]        M4_INIT   = 2'(FIRST_YEAR % 4);
   localparam logic [6:0]        M100_INIT = 7'(FIRST_YEAR % 100);
   localparam logic [8:0]        M400_INIT = 9'(FIRST_YEAR % 400);

   logic [YEAR_W-1:0] year_ff, year_in;
   logic [1:0]        m4_ff, m4_in;
   logic [6:0]        m100_ff, m100_in;
   logic [8:0]        m400_ff, m400_in;

   // Next values: reload at the window start or advance one year
   always_comb begin
      year_in = year_ff;
      m4_in   = m4_ff;
      m100_in = m100_ff;
      m400_in = m400_ff;
      if (load) begin
         year_in = Y_INIT;
         m4_in   = M4_INIT;
         m100_in = M100_INIT;
         m400_in = M400_INIT;
      end else if (step) begin
         year_in = year_ff + 1'b1;
         m4_in   = m4_ff + 1'b1;
         m100_in = (m100_ff == 7'd99)  ? '0 : m100_ff + 1'b1;
         m400_in = (m400_ff == 9'd399) ? '0 : m400_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      year_ff <= year_in;
      m4_ff   <= m4_in;
      m100_ff <= m100_in;
      m400_ff <= m400_in;
   end

   assign year = year_ff;
   assign leap = ((m4_ff == '0) && (m100_ff != '0)) || (m400_ff == '0);

endmodule

`default_nettype wire

// File: rtl/calendar_date_day_number_convert.sv
// Top level: date to day-number converter, sequencer around a shared adder.
//
//   port group   dir   handshake            payload
//   request      in    start / busy         req_data (req_type)
//   response     out   rsp_strobe           rsp_data (rsp_type)
//
// A request is taken when start is high and busy low; busy stays high until
// the response strobe. Encode and an in-window decode step the shared adder one
// year or one month a cycle over the years and months passed. The response is
// shown for one cycle only and cannot be held off. Reset is synchronous and
// returns the sequencer to idle; no clearing pass.
`default_nettype none

module calendar_date_day_number_convert #(
   parameter int unsigned FIRST_YEAR = cddn_pkg::DEF_FIRST_YEAR,
   parameter int unsigned LAST_YEAR  = cddn_pkg::DEF_LAST_YEAR
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire cddn_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output cddn_pkg::rsp_type      rsp_data
);
   import cddn_pkg::*;

   localparam logic [YEAR_W-1:0] FIRST_Y = YEAR_W'(FIRST_YEAR);
   localparam logic [YEAR_W-1:0] LAST_Y  = YEAR_W'(LAST_YEAR);

   state_type            state_ff, state_in;
   req_type              req_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [MONTH_W-1:0]   month_ff;
   logic                 ok_ff;
   ctl_type              ctl;
   unit_res_type         unit_res;
   logic [YEAR_W-1:0]    year_w;
   logic                 leap_w;
   logic [LEN_W-1:0]     operand;
   logic                 is_decode;
   logic                 enc_args_ok;
   logic                 year_before;
   logic                 year_in_window;
   logic                 day_ok;
   logic                 month_before;
   logic                 rem_gt;
   logic                 range_ok;
   logic [COUNT_W-1:0]   count_res;

   cddn_year #(
      .FIRST_YEAR (FIRST_YEAR)
   ) u_year (
      .clock (clock),
      .load  (ctl.load),
      .step  (ctl.year_step),
      .year  (year_w),
      .leap  (leap_w)
   );

   // Year or month length into the shared adder
   assign operand = ctl.use_year ? year_len(leap_w)
                                 : LEN_W'(month_len(month_ff, leap_w));

   cddn_unit u_unit (
      .a   (acc_ff),
      .b   (operand),
      .sub (ctl.sub),
      .res (unit_res)
   );

   // Sequencer conditions
   assign is_decode      = (req_ff.opcode == OP_DECODE);
   assign enc_args_ok    = (req_ff.month_in >= FIRST_MONTH)
                        && (req_ff.month_in <= MONTHS_PER_YEAR)
                        && (req_ff.year_in >= FIRST_Y) && (req_ff.year_in <= LAST_Y);
   assign year_before    = (year_w < req_ff.year_in);
   assign year_in_window = (year_w <= LAST_Y);
   assign day_ok         = (req_ff.day_in != '0)
                        && (req_ff.day_in <= month_len(req_ff.month_in, leap_w));
   assign month_before   = (month_ff < req_ff.month_in);
   assign rem_gt         = ~unit_res.borrow & ~unit_res.zero;
   assign range_ok       = (acc_ff[ACC_W-1:COUNT_W] == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_data.opcode == OP_DECODE) ? ST_DEC_CHECK : ST_ENC_CHECK;
            end
         end
         ST_ENC_CHECK: state_in = enc_args_ok ? ST_ENC_YEAR : ST_RESULT;
         ST_ENC_YEAR:  state_in = year_before ? ST_ENC_YEAR : ST_ENC_DAY;
         ST_ENC_DAY:   state_in = day_ok ? ST_ENC_MONTH : ST_RESULT;
         ST_ENC_MONTH: state_in = month_before ? ST_ENC_MONTH : ST_ENC_RANGE;
         ST_ENC_RANGE: state_in = ST_RESULT;
         ST_DEC_CHECK: state_in = (req_ff.count_in == '0) ? ST_RESULT : ST_DEC_YEAR;
         ST_DEC_YEAR: begin
            priority if (year_in_window && rem_gt) state_in = ST_DEC_YEAR;
            else if (year_in_window)               state_in = ST_DEC_MONTH;
            else                                   state_in = ST_RESULT;
         end
         ST_DEC_MONTH: begin
            state_in = ((month_ff < MONTHS_PER_YEAR) && rem_gt) ? ST_DEC_MONTH
                                                                 : ST_RESULT;
         end
         ST_RESULT:    state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Controls per state
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE: ctl.load = start;
         ST_ENC_YEAR: begin
            ctl.use_year = 1'b1;
            if (year_before) begin
               ctl.acc_we    = 1'b1;
               ctl.year_step = 1'b1;
            end
         end
         ST_ENC_MONTH: begin
            if (month_before) begin
               ctl.acc_we     = 1'b1;
               ctl.month_step = 1'b1;
            end
         end
         ST_ENC_RANGE: ctl.ok_set = range_ok;
         ST_DEC_YEAR: begin
            ctl.sub      = 1'b1;
            ctl.use_year = 1'b1;
            if (year_in_window && rem_gt) begin
               ctl.acc_we    = 1'b1;
               ctl.year_step = 1'b1;
            end else if (year_in_window) begin
               ctl.ok_set = 1'b1;
            end
         end
         ST_DEC_MONTH: begin
            ctl.sub = 1'b1;
            if ((month_ff < MONTHS_PER_YEAR) && rem_gt) begin
               ctl.acc_we     = 1'b1;
               ctl.month_step = 1'b1;
            end
         end
         ST_RESULT: ctl.strobe = 1'b1;
         default:   ctl = '0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctl.load) begin
            ok_ff <= 1'b0;
         end else if (ctl.ok_set) begin
            ok_ff <= 1'b1;
         end
      end
   end

   // Request capture, running count and month counter
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff   <= req_data;
         acc_ff   <= (req_data.opcode == OP_DECODE) ? ACC_W'(req_data.count_in)
                                                    : ACC_W'(req_data.day_in);
         month_ff <= FIRST_MONTH;
      end else begin
         if (ctl.acc_we) begin
            acc_ff <= unit_res.sum;
         end
         if (ctl.month_step) begin
            month_ff <= month_ff + 1'b1;
         end
      end
   end

   // Response fields
   always_comb begin
      if (is_decode) begin
         count_res          = req_ff.count_in;
         rsp_data.month_out = ok_ff ? month_ff : '0;
         rsp_data.day_out   = ok_ff ? acc_ff[DAY_W-1:0] : '0;
         rsp_data.year_out  = ok_ff ? year_w : '0;
      end else begin
         count_res          = ok_ff ? acc_ff[COUNT_W-1:0] : COUNT_W'(1);
         rsp_data.month_out = req_ff.month_in;
         rsp_data.day_out   = req_ff.day_in;
         rsp_data.year_out  = req_ff.year_in;
      end
      rsp_data.count_out = count_res;
      rsp_data.weekday   = weekday_of(count_res);
      rsp_data.valid_res = ok_ff;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = ctl.strobe;

endmodule

`default_nettype wire

// File: tb/sv/calendar_date_day_number_convert_test.sv
// Self-checking testbench for the calendar date / day number converter.
`default_nettype none

module calendar_date_day_number_convert_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cddn_pkg::*;

   localparam int unsigned CLOCK_PERIOD  = 10;
   localparam int unsigned RESET_CYCLES  = 9;
   localparam int unsigned RANDOM_ITEMS  = 1525;
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned DRAIN_CYCLES  = 250;
   localparam int unsigned PAUSE_EVERY   = 500;
   localparam int unsigned COUNT_LIMIT   = 131071;
   localparam int unsigned W_FIRST       = DEF_FIRST_YEAR;
   localparam int unsigned W_LAST        = DEF_LAST_YEAR;

   // One row of the directed table; rsp is typed in only where known is set
   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } stimulus_row_type;

   // A request in flight: what kind it was and the response it must give
   typedef struct {
      opcode_type op;
      rsp_type    rsp;
   } awaited_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   awaited_type      awaited_conversions [$];
   awaited_type      next_conversion;
   stimulus_row_type directed_rows [$];
   int unsigned      mismatch_count  = 0;
   int unsigned      encodes_checked = 0;
   int unsigned      encodes_valid   = 0;
   int unsigned      decodes_checked = 0;
   int unsigned      decodes_valid   = 0;
   int unsigned      window_days;

   calendar_date_day_number_convert u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------
   // Calendar arithmetic for the predictor
   // ---------------------------------------------------------------
   function automatic bit gregorian_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_of_month(input int unsigned m, input int unsigned y);
      int unsigned n;
      case (m)
         2:             n = gregorian_leap(y) ? 29 : 28;
         4, 6, 9, 11:   n = 30;
         default:       n = 31;
      endcase
      return n;
   endfunction

   function automatic int unsigned days_of_year(input int unsigned y);
      return gregorian_leap(y) ? 366 : 365;
   endfunction

   function automatic logic [WDAY_W-1:0] day_of_week(input int unsigned c);
      return WDAY_W'(((c + 5) % 7) + 1);
   endfunction

   // Expected response for one request
   function automatic rsp_type convert_date(input req_type r);
      rsp_type     p;
      int unsigned m, d, y, c, rem, yy, mm;
      bit          ok;
      m = r.month_in;
      d = r.day_in;
      y = r.year_in;
      c = r.count_in;
      if (r.opcode == OP_ENCODE) begin
         ok = (m >= 1) && (m <= 12) && (y >= W_FIRST) && (y <= W_LAST) &&
              (d >= 1) && (d <= days_of_month(m, y));
         rem = 1;
         if (ok) begin
            rem = d;
            for (yy = W_FIRST; yy < y; yy++) rem += days_of_year(yy);
            for (mm = 1; mm < m; mm++) rem += days_of_month(mm, y);
            // too wide for the count field: treated as an invalid date
            if (rem > COUNT_LIMIT) begin
               ok  = 1'b0;
               rem = 1;
            end
         end
         p.count_out = COUNT_W'(rem);
         p.month_out = r.month_in;
         p.day_out   = r.day_in;
         p.year_out  = r.year_in;
         p.weekday   = day_of_week(rem);
         p.valid_res = ok;
      end else begin
         rem = c;
         yy  = W_FIRST;
         mm  = 1;
         ok  = 1'b0;
         if (rem >= 1) begin
            while (yy <= W_LAST && rem > days_of_year(yy)) begin
               rem -= days_of_year(yy);
               yy++;
            end
            if (yy <= W_LAST) begin
               ok = 1'b1;
               while (mm < 12 && rem > days_of_month(mm, yy)) begin
                  rem -= days_of_month(mm, yy);
                  mm++;
               end
            end
         end
         p.count_out = r.count_in;
         p.month_out = ok ? MONTH_W'(mm) : '0;
         p.day_out   = ok ? DAY_W'(rem) : '0;
         p.year_out  = ok ? YEAR_W'(yy) : '0;
         p.weekday   = day_of_week(c);
         p.valid_res = ok;
      end
      return p;
   endfunction

   // ---------------------------------------------------------------
   // Request and response builders
   // ---------------------------------------------------------------
   function automatic req_type encode_req(input int unsigned m, input int unsigned d,
                                          input int unsigned y, input int unsigned junk);
      req_type r;
      r.opcode   = OP_ENCODE;
      r.month_in = MONTH_W'(m);
      r.day_in   = DAY_W'(d);
      r.year_in  = YEAR_W'(y);
      r.count_in = COUNT_W'(junk);
      return r;
   endfunction

   function automatic req_type decode_req(input int unsigned c, input int unsigned m,
                                          input int unsigned d, input int unsigned y);
      req_type r;
      r          = encode_req(m, d, y, c);
      r.opcode   = OP_DECODE;
      return r;
   endfunction

   function automatic rsp_type known_rsp(input int unsigned c, input int unsigned m,
                                         input int unsigned d, input int unsigned y,
                                         input int unsigned wd, input bit v);
      rsp_type p;
      p.count_out = COUNT_W'(c);
      p.month_out = MONTH_W'(m);
      p.day_out   = DAY_W'(d);
      p.year_out  = YEAR_W'(y);
      p.weekday   = WDAY_W'(wd);
      p.valid_res = v;
      return p;
   endfunction

   // Random request, weighted towards well-formed dates and in-window counts
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick, y, m, d, sel;
      pick = $urandom_range(99);
      r    = req_type'({$urandom, $urandom});
      if (pick < 40) begin
         y = $urandom_range(W_LAST, W_FIRST);
         m = $urandom_range(12, 1);
         d = $urandom_range(days_of_month(m, y), 1);
         r = encode_req(m, d, y, $urandom);
      end else if (pick < 52) begin
         // around the window edges, month ends and leap days
         sel = $urandom_range(5);
         case (sel)
            0:       y = W_FIRST - 1;
            1:       y = W_FIRST;
            2:       y = 2000;
            3:       y = 4 * $urandom_range(W_LAST / 4, W_FIRST / 4);
            4:       y = W_LAST;
            default: y = W_LAST + 1;
         endcase
         m = ($urandom_range(1) == 0) ? 2 : $urandom_range(13, 0);
         d = ($urandom_range(7) == 0) ? 0 : $urandom_range(31, 27);
         r = encode_req(m, d, y, $urandom);
      end else if (pick < 65) begin
         r.opcode = OP_ENCODE;
      end else if (pick < 88) begin
         r = decode_req($urandom_range(window_days, 1), $urandom, $urandom, $urandom);
      end else if (pick < 93) begin
         sel = $urandom_range(5);
         case (sel)
            0:       d = 0;
            1:       d = 1;
            2:       d = window_days - 1;
            3:       d = window_days;
            4:       d = window_days + 1;
            default: d = COUNT_LIMIT;
         endcase
         r = decode_req(d, $urandom, $urandom, $urandom);
      end else begin
         r.opcode = OP_DECODE;
      end
      return r;
   endfunction

   // Idle cycles before the next request: mostly none or short, a few long
   function automatic int unsigned idle_gap();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 35) return 0;
      if (pick < 85) return $urandom_range(4, 1);
      if (pick < 97) return $urandom_range(40, 5);
      return $urandom_range(300, 100);
   endfunction

   // ---------------------------------------------------------------
   // Request driver: changes inputs on the falling edge only
   // ---------------------------------------------------------------
   task automatic issue_request(input req_type r, input rsp_type want, input int unsigned gap);
      if (gap != 0) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= req_type'({$urandom, $urandom});
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start                <= 1'b1;
      req_data             <= r;
      next_conversion.op   = opcode_type'(r.opcode);
      next_conversion.rsp  = want;
      do @(posedge clock); while (busy);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------
   // Response checker and request tracker, sampled on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      awaited_type w;
      if (!reset) begin
         if (rsp_strobe) begin
            if (awaited_conversions.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               w = awaited_conversions.pop_front();
               compare_field("count_out", w.rsp.count_out, rsp_data.count_out);
               compare_field("month_out", w.rsp.month_out, rsp_data.month_out);
               compare_field("day_out",   w.rsp.day_out,   rsp_data.day_out);
               compare_field("year_out",  w.rsp.year_out,  rsp_data.year_out);
               compare_field("weekday",   w.rsp.weekday,   rsp_data.weekday);
               compare_field("valid_res", w.rsp.valid_res, rsp_data.valid_res);
               if (w.op == OP_ENCODE) begin
                  encodes_checked++;
                  encodes_valid += w.rsp.valid_res;
               end else begin
                  decodes_checked++;
                  decodes_valid += w.rsp.valid_res;
               end
            end
         end
         // a new request cannot be taken on the same edge as a response: busy is still high
         if (start && !busy) awaited_conversions.push_back(next_conversion);
      end
   end

   // Watchdog: too long with no request taken and no response seen
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) quiet = 0;
         else quiet++;
      end
      $display("watchdog: %0d cycles with no request or response", STALL_LIMIT);
      $display("** calendar_date_day_number_convert: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin : stimulus
      int unsigned     i, gap, y;
      req_type         r;
      rsp_type         want;

      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;

      window_days = 0;
      for (y = W_FIRST; y <= W_LAST; y++) window_days += days_of_year(y);

      // Directed: extremes, invalid dates, leap rule, window edges
      directed_rows = '{
         '{encode_req(1, 1, W_FIRST, 0),        1'b1, known_rsp(1, 1, 1, W_FIRST, 7, 1'b1)},
         '{encode_req(12, 31, W_LAST, 'h1ffff), 1'b0, '0},
         '{encode_req(0, 15, 2000, 0),          1'b1, known_rsp(1, 0, 15, 2000, 7, 1'b0)},
         '{encode_req(13, 1, 1950, 0),          1'b1, known_rsp(1, 13, 1, 1950, 7, 1'b0)},
         '{encode_req(15, 31, 16383, 'h1ffff),  1'b1, known_rsp(1, 15, 31, 16383, 7, 1'b0)},
         '{encode_req(0, 0, 0, 0),              1'b1, known_rsp(1, 0, 0, 0, 7, 1'b0)},
         '{encode_req(4, 31, 2001, 0),          1'b1, known_rsp(1, 4, 31, 2001, 7, 1'b0)},
         '{encode_req(6, 0, 1999, 0),           1'b1, known_rsp(1, 6, 0, 1999, 7, 1'b0)},
         '{encode_req(2, 29, 1900, 0),          1'b1, known_rsp(1, 2, 29, 1900, 7, 1'b0)},
         '{encode_req(2, 29, 2001, 0),          1'b1, known_rsp(1, 2, 29, 2001, 7, 1'b0)},
         '{encode_req(1, 1, W_FIRST - 1, 0),    1'b1,
           known_rsp(1, 1, 1, W_FIRST - 1, 7, 1'b0)},
         '{encode_req(1, 1, W_LAST + 1, 0),     1'b1,
           known_rsp(1, 1, 1, W_LAST + 1, 7, 1'b0)},
         '{encode_req(2, 29, 2000, 0),          1'b0, '0},
         '{encode_req(2, 29, 2096, 0),          1'b0, '0},
         '{encode_req(3, 1, 1900, 0),           1'b0, '0},
         '{encode_req(12, 31, 1900, 0),         1'b0, '0},
         '{encode_req(1, 1, W_LAST, 0),         1'b0, '0},
         '{decode_req(0, 15, 31, 16383),        1'b1, known_rsp(0, 0, 0, 0, 6, 1'b0)},
         '{decode_req(1, 0, 0, 0),              1'b1, known_rsp(1, 1, 1, W_FIRST, 7, 1'b1)},
         '{decode_req(59, 0, 0, 0),             1'b0, '0},
         '{decode_req(60, 0, 0, 0),             1'b0, '0},
         '{decode_req(366, 0, 0, 0),            1'b0, '0},
         '{decode_req(window_days, 0, 0, 0),    1'b0, '0},
         '{decode_req(window_days + 1, 0, 0, 0), 1'b0, '0},
         '{decode_req(COUNT_LIMIT, 15, 31, 16383), 1'b0, '0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         want = directed_rows[i].known ? directed_rows[i].rsp
                                       : convert_date(directed_rows[i].req);
         issue_request(directed_rows[i].req, want, idle_gap());
      end

      // Random requests, with back-to-back stretches and occasional full drains
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PAUSE_EVERY == PAUSE_EVERY / 2) begin
            @(negedge clock);
            start <= 1'b0;
            while (awaited_conversions.size() != 0) @(negedge clock);
         end
         gap = (i % 200 < 20) ? 0 : idle_gap();
         r   = random_request();
         issue_request(r, convert_date(r), gap);
      end

      @(negedge clock);
      start <= 1'b0;
      while (awaited_conversions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d encodes (%0d valid dates) and %0d decodes (%0d in window),",
               encodes_checked, encodes_valid, decodes_checked, decodes_valid);
      $display("with random gaps and back-to-back requests; %0d mismatches.", mismatch_count);
      if (mismatch_count == 0) begin
         $display("** calendar_date_day_number_convert: PASSED **");
      end else begin
         $display("** calendar_date_day_number_convert: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
